/* hdl/sgr_pkg.sv */
// shared types and constants for the sgr escape attribute parser
// no dependencies; imported by sgr_escape_attribute_parser

package sgr_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgColorsCount  = 3'd0,
    CfgDefaultFg    = 3'd1,
    CfgDefaultBg    = 3'd2,
    CfgDefaultAttrs = 3'd3
  } cfg_idx_e;

  // characters
  localparam logic [7:0] ChEsc  = 8'h1B;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChM    = 8'h6D;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  // sgr parameter codes
  localparam int unsigned SgrReset    = 0;
  localparam int unsigned SgrBold     = 1;
  localparam int unsigned SgrDim      = 2;
  localparam int unsigned SgrRev      = 3;
  localparam int unsigned SgrUl       = 4;
  localparam int unsigned SgrBlink    = 5;
  localparam int unsigned SgrBlinkFst = 6;
  localparam int unsigned SgrRevAlt   = 7;
  localparam int unsigned SgrNormal   = 22;
  localparam int unsigned SgrUlOff    = 24;
  localparam int unsigned SgrBlinkOff = 25;
  localparam int unsigned SgrRevOff   = 27;
  localparam int unsigned SgrFgFirst  = 30;
  localparam int unsigned SgrFgLast   = 37;
  localparam int unsigned SgrFgExt    = 38;
  localparam int unsigned SgrFgDflt   = 39;
  localparam int unsigned SgrBgFirst  = 40;
  localparam int unsigned SgrBgLast   = 47;
  localparam int unsigned SgrBgExt    = 48;
  localparam int unsigned SgrBgDflt   = 49;
  localparam int unsigned SgrExtIdx   = 5;

  // attribute bits
  localparam logic [4:0] AttrBold  = 5'b00001;
  localparam logic [4:0] AttrDim   = 5'b00010;
  localparam logic [4:0] AttrRev   = 5'b00100;
  localparam logic [4:0] AttrUl    = 5'b01000;
  localparam logic [4:0] AttrBlink = 5'b10000;

  localparam logic [8:0] ColorNone  = 9'h1FF;
  localparam logic [8:0] ColorLimit = 9'd256;

endpackage

/* hdl/sgr_escape_attribute_parser.sv */
// sgr escape attribute parser: byte stream in, byte plus current colors and attributes out
// depends on sgr_pkg
//
//  channel  | dir | payload (low bit first)                           | handshake
//  s_axis   | in  | tdata: byte_in                                     | tvalid/tready
//  m_axis   | out | tdata: byte_out, fg_color, bg_color, attr_bits     | tvalid/tready
//           |     | tuser: is_text, seq_done                           |
//  cfg      | in  | cfg_index_i, cfg_data_i                            | cfg_valid_i/cfg_ready_o
//
// one byte per cycle while the skid entry is empty; results are registered
// parser state, accumulator and colors update in one step in front of the output register
// a two-entry output stage (register plus skid) keeps input open while one result waits
// reset: colors -1, attributes 0, normal text, config at its defaults
// cfg writes are always taken

module sgr_escape_attribute_parser #(
  parameter int ACC_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // byte_out, fg_color, bg_color, attr_bits, zero pad
  output logic [1:0]  m_axis_tuser,   // is_text, seq_done
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  sgr_pkg::cfg_idx_e cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  import sgr_pkg::*;

  localparam int CmpW = (ACC_WIDTH > 9) ? ACC_WIDTH : 9;
  localparam int ProdW = ACC_WIDTH + 4;

  typedef enum logic [2:0] {
    PhNormal, PhSkip, PhStart, PhNum, PhIgnore
  } phase_e;

  typedef enum logic [2:0] {
    CmShort, CmFgPrefix, CmBgPrefix, CmFgWait, CmBgWait
  } cmode_e;

  phase_e phase_q, phase_d;
  cmode_e cmode_q, cmode_d;
  logic [ACC_WIDTH-1:0] acc_q, acc_d;
  logic [8:0] fg_q, fg_d, bg_q, bg_d;
  logic [4:0] attr_q, attr_d;

  logic [8:0] colors_q, def_fg_q, def_bg_q;
  logic [4:0] def_attrs_q;

  logic [7:0] b;
  logic digit, text, done, take;
  logic [ACC_WIDTH-1:0] n, base;
  logic [CmpW-1:0] n_ext;
  logic [ProdW-1:0] prod;
  logic [8:0] limit;
  logic ext_ok;

  logic in_fire, out_fire;
  logic out_valid_q, skid_valid_q;
  logic [31:0] out_data_q, skid_data_q, res_data;
  logic [1:0] out_user_q, skid_user_q, res_user;

  assign b = s_axis_tdata;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign limit = (colors_q > ColorLimit) ? ColorLimit : colors_q;
  assign n_ext = CmpW'(n);
  assign ext_ok = n_ext < CmpW'(limit);

  always_comb begin
    phase_d = phase_q;
    cmode_d = cmode_q;
    acc_d = acc_q;
    fg_d = fg_q;
    bg_d = bg_q;
    attr_d = attr_q;
    text = 1'b0;
    done = 1'b0;
    take = 1'b0;
    n = '0;
    digit = b inside {[ChZero:ChNine]};
    base = (phase_q == PhNum) ? acc_q : '0;
    prod = (ProdW'(base) << 3) + (ProdW'(base) << 1) + ProdW'(b - ChZero);

    case (phase_q)
      PhNormal: begin
        if (b == ChEsc) phase_d = PhSkip;
        else text = 1'b1;
      end
      PhSkip: begin
        if (b == ChM) begin
          take = 1'b1;
          done = 1'b1;
          phase_d = PhNormal;
        end else begin
          phase_d = PhStart;
        end
      end
      PhStart, PhNum: begin
        if (digit) begin
          acc_d = (prod[ProdW-1:ACC_WIDTH] != '0) ? '1 : prod[ACC_WIDTH-1:0];
          phase_d = PhNum;
        end else begin
          n = base;
          take = 1'b1;
          acc_d = '0;
          if (b == ChSemi) begin
            phase_d = PhStart;
          end else if (b == ChM) begin
            done = 1'b1;
            phase_d = PhNormal;
          end else begin
            phase_d = PhIgnore;
          end
        end
      end
      default: begin
        if (b == ChM) begin
          done = 1'b1;
          phase_d = PhNormal;
        end
      end
    endcase

    if (take) begin
      case (cmode_q)
        CmFgPrefix: cmode_d = (n == ACC_WIDTH'(SgrExtIdx)) ? CmFgWait : CmShort;
        CmBgPrefix: cmode_d = (n == ACC_WIDTH'(SgrExtIdx)) ? CmBgWait : CmShort;
        CmFgWait: begin
          if (ext_ok) fg_d = n_ext[8:0];
          cmode_d = CmShort;
        end
        CmBgWait: begin
          if (ext_ok) bg_d = n_ext[8:0];
          cmode_d = CmShort;
        end
        default: begin
          if (n == ACC_WIDTH'(SgrFgExt)) begin
            cmode_d = CmFgPrefix;
          end else if (n == ACC_WIDTH'(SgrBgExt)) begin
            cmode_d = CmBgPrefix;
          end else if (n == ACC_WIDTH'(SgrReset)) begin
            attr_d = def_attrs_q;
            fg_d = def_fg_q;
            bg_d = def_bg_q;
          end else if (n == ACC_WIDTH'(SgrBold)) begin
            attr_d = attr_q | AttrBold;
          end else if (n == ACC_WIDTH'(SgrDim)) begin
            attr_d = attr_q | AttrDim;
          end else if (n == ACC_WIDTH'(SgrRev) || n == ACC_WIDTH'(SgrRevAlt)) begin
            attr_d = attr_q | AttrRev;
          end else if (n == ACC_WIDTH'(SgrUl)) begin
            attr_d = attr_q | AttrUl;
          end else if (n == ACC_WIDTH'(SgrBlink) || n == ACC_WIDTH'(SgrBlinkFst)) begin
            attr_d = attr_q | AttrBlink;
          end else if (n == ACC_WIDTH'(SgrNormal)) begin
            attr_d = '0;
          end else if (n == ACC_WIDTH'(SgrUlOff)) begin
            attr_d = attr_q & ~AttrUl;
          end else if (n == ACC_WIDTH'(SgrBlinkOff)) begin
            attr_d = attr_q & ~AttrBlink;
          end else if (n == ACC_WIDTH'(SgrRevOff)) begin
            attr_d = attr_q & ~AttrRev;
          end else if (n >= ACC_WIDTH'(SgrFgFirst) && n <= ACC_WIDTH'(SgrFgLast)) begin
            fg_d = 9'(n - ACC_WIDTH'(SgrFgFirst));
          end else if (n == ACC_WIDTH'(SgrFgDflt)) begin
            fg_d = ColorNone;
          end else if (n >= ACC_WIDTH'(SgrBgFirst) && n <= ACC_WIDTH'(SgrBgLast)) begin
            bg_d = 9'(n - ACC_WIDTH'(SgrBgFirst));
          end else if (n == ACC_WIDTH'(SgrBgDflt)) begin
            bg_d = ColorNone;
          end
        end
      endcase
    end

    res_data = {1'b0, attr_d, bg_d, fg_d, b};
    res_user = {done, text};
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNormal;
      cmode_q <= CmShort;
      acc_q <= '0;
      fg_q <= ColorNone;
      bg_q <= ColorNone;
      attr_q <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      cmode_q <= cmode_d;
      acc_q <= acc_d;
      fg_q <= fg_d;
      bg_q <= bg_d;
      attr_q <= attr_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colors_q <= ColorLimit;
      def_fg_q <= ColorNone;
      def_bg_q <= ColorNone;
      def_attrs_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgColorsCount:  colors_q <= cfg_data_i;
        CfgDefaultFg:    def_fg_q <= cfg_data_i;
        CfgDefaultBg:    def_bg_q <= cfg_data_i;
        CfgDefaultAttrs: def_attrs_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // output register and skid stage: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output register and skid stage: payload
  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end else if (in_fire) begin
        out_data_q <= res_data;
        out_user_q <= res_user;
      end
    end else if (in_fire) begin
      skid_data_q <= res_data;
      skid_user_q <= res_user;
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_user_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_text_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result flagged as text and sequence end");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && m_axis_tvalid && !m_axis_tready) |=> skid_valid_q)
    else $error("transfer during output stall not captured");

  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhNormal || phase_q == PhSkip) |-> (acc_q == '0))
    else $error("accumulator not cleared outside parameter parsing");

endmodule
